/* hdl/cau_pkg.sv */
// Package: constants, request types and stage records of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int MW        = PW + 1;
    localparam int DIV_STG   = DW;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [2:0]           action;
        logic signed [DW-1:0] a_real;
        logic signed [DW-1:0] a_imag;
        logic signed [DW-1:0] b_real;
        logic signed [DW-1:0] b_imag;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] res_real;
        logic signed [DW-1:0] res_imag;
        logic [1:0]           status;
        logic                 is_equal;
    } t_out;

    typedef struct packed {
        logic          v;
        logic [2:0]    act;
        logic [DW-1:0] m_ar, m_ai, m_br, m_bi;
        logic          s_ar, s_ai, s_br, s_bi;
        t_out          res;
    } t_s1;

    typedef struct packed {
        logic          v;
        logic [2:0]    act;
        logic [PW-1:0] p_arbr, p_aibi, p_aibr, p_arbi, p_brbr, p_bibi;
        logic          s_ar, s_ai, s_br, s_bi;
        t_out          res;
    } t_s2;

    typedef struct packed {
        logic                 v;
        logic [2:0]           act;
        logic signed [MW-1:0] pm_r, pm_i;
        logic [PW-1:0]        nm_r, nm_i;
        logic                 ng_r, ng_i;
        logic [PW-1:0]        den;
        t_out                 res;
    } t_s3;

    typedef struct packed {
        logic          v;
        logic [2:0]    act;
        t_out          res;
        logic [PW-1:0] den;
        logic [PW-1:0] rem_r, rem_i;
        logic [DW-1:0] nlo_r, nlo_i;
        logic [DW-1:0] q_r, q_i;
        logic          ng_r, ng_i;
        logic          ov_r, ov_i;
    } t_dv;

endpackage
`default_nettype wire

/* hdl/complex_arith_unit_top.sv */
// Top level: pipelined complex add, subtract, multiply, divide and compare in fixed point.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//  cfg     | input     | i_cfg_we                  | i_cfg_wdata (equal tolerance)
//
// One request per cycle while no stall holds the pipeline; four operand stages, 32 divider stages
// (one quotient bit of each part per stage), one output register.
// Synchronous active-low reset clears the valid bits; tolerance resets to 1.
// A stall propagates back combinationally through full stages only, so empty stages keep filling.
`default_nettype none
module complex_arith_unit_top
    import cau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    logic [15:0] r_tol;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_dv  r_dv [0:DIV_STG];
    t_dv  n_dv [0:DIV_STG];
    logic r_out_v;
    t_out r_out, n_out;

    logic w_rdy_out, w_rdy_s1, w_rdy_s2, w_rdy_s3;
    logic [DIV_STG:0] w_rdy_dv;

    function automatic logic [DW:0] sat33(input logic signed [DW:0] x);
        if (x[DW] != x[DW-1]) begin
            return {1'b1, x[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}}};
        end
        return {1'b0, x[DW-1:0]};
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
        return x[DW-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [DW:0] fin(input logic ng, input logic [DW-1:0] q,
                                        input logic ov);
        logic [DW-1:0] lo, hi;
        lo = {1'b1, {(DW-1){1'b0}}};
        hi = {1'b0, {(DW-1){1'b1}}};
        if (ov) begin
            return {1'b1, ng ? lo : hi};
        end
        if (ng) begin
            if (q > lo) begin
                return {1'b1, lo};
            end
            return {1'b0, ~q + 1'b1};
        end
        if (q[DW-1]) begin
            return {1'b1, hi};
        end
        return {1'b0, q};
    endfunction

    // ready chain
    assign w_rdy_out = !r_out_v || !i_out_stall;
    always_comb begin
        w_rdy_dv[DIV_STG] = !r_dv[DIV_STG].v || w_rdy_out;
        for (int k = DIV_STG - 1; k >= 0; k--) begin
            w_rdy_dv[k] = !r_dv[k].v || w_rdy_dv[k+1];
        end
    end
    assign w_rdy_s3   = !r_s3.v || w_rdy_dv[0];
    assign w_rdy_s2   = !r_s2.v || w_rdy_s3;
    assign w_rdy_s1   = !r_s1.v || w_rdy_s2;
    assign o_in_stall = !w_rdy_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd1;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // stage 1: add, subtract, compare, magnitudes
    always_comb begin
        logic signed [DW:0] ar, ai, br, bi, sr, si, dr, di;
        logic [DW:0] ur, ui;
        logic [DW:0] xr, xi;
        ar = {i_in_data.a_real[DW-1], i_in_data.a_real};
        ai = {i_in_data.a_imag[DW-1], i_in_data.a_imag};
        br = {i_in_data.b_real[DW-1], i_in_data.b_real};
        bi = {i_in_data.b_imag[DW-1], i_in_data.b_imag};
        sr = ar + br;
        si = ai + bi;
        dr = ar - br;
        di = ai - bi;
        ur = dr[DW] ? (~dr + 1'b1) : dr;
        ui = di[DW] ? (~di + 1'b1) : di;
        n_s1      = '0;
        n_s1.v    = i_in_valid;
        n_s1.act  = i_in_data.action;
        n_s1.m_ar = mag(i_in_data.a_real);
        n_s1.m_ai = mag(i_in_data.a_imag);
        n_s1.m_br = mag(i_in_data.b_real);
        n_s1.m_bi = mag(i_in_data.b_imag);
        n_s1.s_ar = i_in_data.a_real[DW-1];
        n_s1.s_ai = i_in_data.a_imag[DW-1];
        n_s1.s_br = i_in_data.b_real[DW-1];
        n_s1.s_bi = i_in_data.b_imag[DW-1];
        xr = '0;
        xi = '0;
        unique case (i_in_data.action)
            ACT_ADD: begin
                xr = sat33(sr);
                xi = sat33(si);
            end
            ACT_SUB: begin
                xr = sat33(dr);
                xi = sat33(di);
            end
            ACT_CMP: begin
                n_s1.res.is_equal = (ur <= {{(DW-15){1'b0}}, r_tol})
                                 && (ui <= {{(DW-15){1'b0}}, r_tol});
            end
            default: begin
            end
        endcase
        n_s1.res.res_real = xr[DW-1:0];
        n_s1.res.res_imag = xi[DW-1:0];
        n_s1.res.status   = (xr[DW] || xi[DW]) ? ST_SAT : ST_OK;
    end

    // stage 2: magnitude products
    always_comb begin
        n_s2        = '0;
        n_s2.v      = r_s1.v;
        n_s2.act    = r_s1.act;
        n_s2.res    = r_s1.res;
        n_s2.s_ar   = r_s1.s_ar;
        n_s2.s_ai   = r_s1.s_ai;
        n_s2.s_br   = r_s1.s_br;
        n_s2.s_bi   = r_s1.s_bi;
        n_s2.p_arbr = PW'(r_s1.m_ar) * PW'(r_s1.m_br);
        n_s2.p_aibi = PW'(r_s1.m_ai) * PW'(r_s1.m_bi);
        n_s2.p_aibr = PW'(r_s1.m_ai) * PW'(r_s1.m_br);
        n_s2.p_arbi = PW'(r_s1.m_ar) * PW'(r_s1.m_bi);
        n_s2.p_brbr = PW'(r_s1.m_br) * PW'(r_s1.m_br);
        n_s2.p_bibi = PW'(r_s1.m_bi) * PW'(r_s1.m_bi);
    end

    // stage 3: product sums, divider numerators and denominator
    always_comb begin
        logic signed [MW-1:0] t1, t2, t3, t4;
        logic n1, n2;
        t1 = (r_s2.s_ar ^ r_s2.s_br) ? -$signed({1'b0, r_s2.p_arbr}) : $signed({1'b0, r_s2.p_arbr});
        t2 = (r_s2.s_ai ^ r_s2.s_bi) ? -$signed({1'b0, r_s2.p_aibi}) : $signed({1'b0, r_s2.p_aibi});
        t3 = (r_s2.s_ar ^ r_s2.s_bi) ? -$signed({1'b0, r_s2.p_arbi}) : $signed({1'b0, r_s2.p_arbi});
        t4 = (r_s2.s_ai ^ r_s2.s_br) ? -$signed({1'b0, r_s2.p_aibr}) : $signed({1'b0, r_s2.p_aibr});
        n_s3      = '0;
        n_s3.v    = r_s2.v;
        n_s3.act  = r_s2.act;
        n_s3.res  = r_s2.res;
        n_s3.pm_r = t1 - t2;
        n_s3.pm_i = t3 + t4;
        n_s3.den  = r_s2.p_brbr + r_s2.p_bibi;
        n1 = r_s2.s_ar ^ r_s2.s_br;
        n2 = r_s2.s_ai ^ r_s2.s_bi;
        if (n1 == n2) begin
            n_s3.nm_r = r_s2.p_arbr + r_s2.p_aibi;
            n_s3.ng_r = n1;
        end else if (r_s2.p_arbr >= r_s2.p_aibi) begin
            n_s3.nm_r = r_s2.p_arbr - r_s2.p_aibi;
            n_s3.ng_r = n1;
        end else begin
            n_s3.nm_r = r_s2.p_aibi - r_s2.p_arbr;
            n_s3.ng_r = n2;
        end
        n1 = r_s2.s_ai ^ r_s2.s_br;
        n2 = !(r_s2.s_ar ^ r_s2.s_bi);
        if (n1 == n2) begin
            n_s3.nm_i = r_s2.p_aibr + r_s2.p_arbi;
            n_s3.ng_i = n1;
        end else if (r_s2.p_aibr >= r_s2.p_arbi) begin
            n_s3.nm_i = r_s2.p_aibr - r_s2.p_arbi;
            n_s3.ng_i = n1;
        end else begin
            n_s3.nm_i = r_s2.p_arbi - r_s2.p_aibr;
            n_s3.ng_i = n2;
        end
    end

    // stage 4: multiply truncation and saturation, divider setup
    always_comb begin
        logic signed [MW-1:0] hr, hi;
        logic [PW-1:0] r0r, r0i;
        logic ovr, ovi;
        hr  = r_s3.pm_r >>> FRAC_BITS;
        hi  = r_s3.pm_i >>> FRAC_BITS;
        ovr = !((&hr[MW-1:DW-1]) || !(|hr[MW-1:DW-1]));
        ovi = !((&hi[MW-1:DW-1]) || !(|hi[MW-1:DW-1]));
        r0r = r_s3.nm_r >> (DW - FRAC_BITS);
        r0i = r_s3.nm_i >> (DW - FRAC_BITS);
        n_dv[0]       = '0;
        n_dv[0].v     = r_s3.v;
        n_dv[0].act   = r_s3.act;
        n_dv[0].res   = r_s3.res;
        n_dv[0].den   = r_s3.den;
        n_dv[0].rem_r = r0r;
        n_dv[0].rem_i = r0i;
        n_dv[0].nlo_r = {r_s3.nm_r[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        n_dv[0].nlo_i = {r_s3.nm_i[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        n_dv[0].ng_r  = r_s3.ng_r;
        n_dv[0].ng_i  = r_s3.ng_i;
        n_dv[0].ov_r  = r0r >= r_s3.den;
        n_dv[0].ov_i  = r0i >= r_s3.den;
        if (r_s3.act == ACT_MUL) begin
            n_dv[0].res.res_real = ovr ? (hr[MW-1] ? {1'b1, {(DW-1){1'b0}}}
                                                   : {1'b0, {(DW-1){1'b1}}}) : hr[DW-1:0];
            n_dv[0].res.res_imag = ovi ? (hi[MW-1] ? {1'b1, {(DW-1){1'b0}}}
                                                   : {1'b0, {(DW-1){1'b1}}}) : hi[DW-1:0];
            n_dv[0].res.status   = (ovr || ovi) ? ST_SAT : ST_OK;
        end
    end

    // divider stages: one quotient bit per part
    for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
        always_comb begin
            logic [PW:0] tr, ti, dd;
            logic gr, gi;
            dd = {1'b0, r_dv[k-1].den};
            tr = {r_dv[k-1].rem_r, r_dv[k-1].nlo_r[DW-1]};
            ti = {r_dv[k-1].rem_i, r_dv[k-1].nlo_i[DW-1]};
            gr = tr >= dd;
            gi = ti >= dd;
            n_dv[k]       = r_dv[k-1];
            n_dv[k].rem_r = gr ? PW'(tr - dd) : tr[PW-1:0];
            n_dv[k].rem_i = gi ? PW'(ti - dd) : ti[PW-1:0];
            n_dv[k].nlo_r = {r_dv[k-1].nlo_r[DW-2:0], 1'b0};
            n_dv[k].nlo_i = {r_dv[k-1].nlo_i[DW-2:0], 1'b0};
            n_dv[k].q_r   = {r_dv[k-1].q_r[DW-2:0], gr};
            n_dv[k].q_i   = {r_dv[k-1].q_i[DW-2:0], gi};
        end
    end

    // output: sign and saturate quotients, flag divide by zero
    always_comb begin
        logic [DW:0] fr, fi;
        fr    = fin(r_dv[DIV_STG].ng_r, r_dv[DIV_STG].q_r, r_dv[DIV_STG].ov_r);
        fi    = fin(r_dv[DIV_STG].ng_i, r_dv[DIV_STG].q_i, r_dv[DIV_STG].ov_i);
        n_out = r_dv[DIV_STG].res;
        if (r_dv[DIV_STG].act == ACT_DIV) begin
            if (r_dv[DIV_STG].den == '0) begin
                n_out.res_real = '0;
                n_out.res_imag = '0;
                n_out.status   = ST_DIVZ;
            end else begin
                n_out.res_real = fr[DW-1:0];
                n_out.res_imag = fi[DW-1:0];
                n_out.status   = (fr[DW] || fi[DW]) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v  <= 1'b0;
            r_s2.v  <= 1'b0;
            r_s3.v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k <= DIV_STG; k++) begin
                r_dv[k].v <= 1'b0;
            end
        end else begin
            if (w_rdy_s1) begin
                r_s1 <= n_s1;
            end
            if (w_rdy_s2) begin
                r_s2 <= n_s2;
            end
            if (w_rdy_s3) begin
                r_s3 <= n_s3;
            end
            for (int k = 0; k <= DIV_STG; k++) begin
                if (w_rdy_dv[k]) begin
                    r_dv[k] <= n_dv[k];
                end
            end
            if (w_rdy_out) begin
                r_out_v <= r_dv[DIV_STG].v;
                r_out   <= n_out;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
